// ===== hdl/dwsr_pkg.sv =====
// Shared types and constants for the dual wheel speed regulator.
`default_nettype none
package dwsr_pkg;

	// Request operation codes
	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_PRELOAD = 2'd1,
		OP_CLEAR   = 2'd2
	} op_t;

	// Drive direction codes; the unused code drives nothing
	typedef enum logic [1:0] {
		DIR_OFF = 2'd0,
		DIR_FWD = 2'd1,
		DIR_REV = 2'd2
	} dir_t;

	// Configuration register indexes
	localparam logic [1:0] REG_LEFT_TARGET  = 2'd0;
	localparam logic [1:0] REG_RIGHT_TARGET = 2'd1;
	localparam logic [1:0] REG_LEFT_DIR     = 2'd2;
	localparam logic [1:0] REG_RIGHT_DIR    = 2'd3;

	localparam int unsigned CFG_DATA_W = 7;

	// Loop constants
	localparam logic [6:0] TARGET_MAX      = 7'd100;
	localparam logic [6:0] SLOW_MIN_TARGET = 7'd20;
	localparam logic [7:0] SLOW_MAX_COUNT  = 8'd20;
	localparam logic [7:0] SLOW_SAT        = 8'd200;
	localparam logic [7:0] COUNT_CLAMP     = 8'd70;
	localparam logic signed [7:0] ERR_LIMIT = 8'sd10;
	localparam logic signed [9:0] DUTY_TOP  = 10'sd99;
	localparam logic [6:0] DUTY_MAX        = 7'd100;

	// Per-wheel settings
	typedef struct packed {
		logic [6:0] target;
		dir_t       dir;
	} wheel_cfg_t;

	// Per-wheel loop state
	typedef struct packed {
		logic [7:0] duty_acc;
		logic [7:0] slow_cnt;
	} wheel_state_t;

endpackage
`default_nettype wire

// ===== hdl/dwsr_cfg.sv =====
// Configuration register file: wheel targets and drive directions.
`default_nettype none
module dwsr_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [dwsr_pkg::CFG_DATA_W-1:0] cfg_data,
	output dwsr_pkg::wheel_cfg_t                 left_cfg,
	output dwsr_pkg::wheel_cfg_t                 right_cfg
);
	import dwsr_pkg::*;

	wheel_cfg_t left_q;
	wheel_cfg_t right_q;
	logic [6:0] target_wr;

	// Targets saturate at the top speed on write
	assign target_wr = (cfg_data > TARGET_MAX) ? TARGET_MAX : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '{target: '0, dir: DIR_OFF};
			right_q <= '{target: '0, dir: DIR_OFF};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT_TARGET:  left_q.target  <= target_wr;
				REG_RIGHT_TARGET: right_q.target <= target_wr;
				REG_LEFT_DIR:     left_q.dir     <= dir_t'(cfg_data[1:0]);
				REG_RIGHT_DIR:    right_q.dir    <= dir_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	assign left_cfg  = left_q;
	assign right_cfg = right_q;

endmodule
`default_nettype wire

// ===== hdl/dwsr_wheel.sv =====
// One wheel's tick update: slow-tick counter, integral duty and channel routing.
`default_nettype none
module dwsr_wheel (
	input  dwsr_pkg::wheel_cfg_t   cfg,
	input  dwsr_pkg::wheel_state_t cur,
	input  wire logic [7:0]        count,
	output dwsr_pkg::wheel_state_t nxt,
	output logic [6:0]             fwd_duty,
	output logic [6:0]             rev_duty
);
	import dwsr_pkg::*;

	logic [11:0]       count_x10;
	logic [11:0]       target_x7;
	logic              slow_hit;
	logic [7:0]        slow_nxt;
	logic [7:0]        count_clamped;
	logic signed [8:0] err_raw;
	logic signed [7:0] err_lim;
	logic signed [9:0] sum;
	logic [6:0]        duty;

	// Slow test: count < floor(7*target/10)  <=>  10*(count+1) <= 7*target
	assign count_x10 = ({4'd0, count} + 12'd1) * 12'd10;
	assign target_x7 = {5'd0, cfg.target} * 12'd7;
	assign slow_hit  = (cfg.target > SLOW_MIN_TARGET) && (count < SLOW_MAX_COUNT)
		&& (count_x10 <= target_x7);

	always_comb begin
		if (!slow_hit)
			slow_nxt = '0;
		else if (cur.slow_cnt >= SLOW_SAT)
			slow_nxt = SLOW_SAT;
		else
			slow_nxt = cur.slow_cnt + 8'd1;
	end

	// Error with clamped count, limited to +/-10
	assign count_clamped = (count > COUNT_CLAMP) ? COUNT_CLAMP : count;
	assign err_raw = $signed({2'b00, cfg.target}) - $signed({1'b0, count_clamped});

	always_comb begin
		if (err_raw > 9'(ERR_LIMIT))
			err_lim = ERR_LIMIT;
		else if (err_raw < -9'(ERR_LIMIT))
			err_lim = -ERR_LIMIT;
		else
			err_lim = err_raw[7:0];
	end

	// Accumulate and clamp to 0..100; a target of 0 or 1 forces zero
	assign sum = $signed({2'b00, cur.duty_acc}) + 10'(err_lim);

	always_comb begin
		if (cfg.target <= 7'd1)
			duty = '0;
		else if (sum < 10'sd0)
			duty = '0;
		else if (sum > DUTY_TOP)
			duty = DUTY_MAX;
		else
			duty = sum[6:0];
	end

	assign nxt = '{duty_acc: {1'b0, duty}, slow_cnt: slow_nxt};

	// Half-bridge routing
	always_comb begin
		fwd_duty = '0;
		rev_duty = '0;
		case (cfg.dir)
			DIR_FWD: fwd_duty = duty;
			DIR_REV: rev_duty = duty;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/dual_wheel_speed_regulator_top.sv =====
// A tick request passes the input register, then the result register; a stalled
// result holds the request in the input register. State updates as it leaves that register.
// Throughput: one request per cycle while no tick is held by a stalled result.
// Preload and clear requests update state and return no result.
// Reset (arst_n low, asynchronous) clears targets, directions, duty
// accumulators, slow counters and all valid flags.
`default_nettype none
module dual_wheel_speed_regulator_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [6:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] operation,
	input  wire logic [7:0] left_count,
	input  wire logic [7:0] right_count,
	input  wire logic [7:0] left_preset,
	input  wire logic [7:0] right_preset,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [6:0]      left_fwd_duty,
	output logic [6:0]      left_rev_duty,
	output logic [6:0]      right_fwd_duty,
	output logic [6:0]      right_rev_duty,
	output logic [7:0]      left_slow_ticks,
	output logic [7:0]      right_slow_ticks
);
	import dwsr_pkg::*;

	wheel_cfg_t   left_cfg, right_cfg;
	wheel_state_t left_q, right_q;
	wheel_state_t left_nxt, right_nxt;
	logic [6:0]   lf, lr, rf, rr;

	logic         valid_s1;
	op_t          op_s1;
	logic [7:0]   lcount_s1, rcount_s1, lpreset_s1, rpreset_s1;
	logic         is_tick, advance, out_free;

	dwsr_cfg u_cfg (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.left_cfg, .right_cfg
	);

	// Input register
	assign out_free = !out_valid || out_ready;
	assign is_tick  = (op_s1 == OP_TICK);
	assign advance  = valid_s1 && (!is_tick || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1      <= op_t'(operation);
			lcount_s1  <= left_count;
			rcount_s1  <= right_count;
			lpreset_s1 <= left_preset;
			rpreset_s1 <= right_preset;
		end
	end

	dwsr_wheel u_left (
		.cfg(left_cfg), .cur(left_q), .count(lcount_s1),
		.nxt(left_nxt), .fwd_duty(lf), .rev_duty(lr)
	);

	dwsr_wheel u_right (
		.cfg(right_cfg), .cur(right_q), .count(rcount_s1),
		.nxt(right_nxt), .fwd_duty(rf), .rev_duty(rr)
	);

	// Loop state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			right_q <= '0;
		end else if (advance) begin
			case (op_s1)
				OP_TICK: begin
					left_q  <= left_nxt;
					right_q <= right_nxt;
				end
				OP_PRELOAD: begin
					left_q.duty_acc  <= lpreset_s1;
					right_q.duty_acc <= rpreset_s1;
				end
				OP_CLEAR: begin
					left_q.slow_cnt  <= '0;
					right_q.slow_cnt <= '0;
				end
				default: ;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (advance && is_tick)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && is_tick) begin
			left_fwd_duty    <= lf;
			left_rev_duty    <= lr;
			right_fwd_duty   <= rf;
			right_rev_duty   <= rr;
			left_slow_ticks  <= left_nxt.slow_cnt;
			right_slow_ticks <= right_nxt.slow_cnt;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/dwsr_checker.sv =====
// Port-level checks for the regulator top and their bind.
`default_nettype none
module dwsr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [6:0] left_fwd_duty,
	input wire logic [6:0] left_rev_duty,
	input wire logic [6:0] right_fwd_duty,
	input wire logic [6:0] right_rev_duty,
	input wire logic [7:0] left_slow_ticks,
	input wire logic [7:0] right_slow_ticks
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_fwd_duty)
		&& $stable(right_fwd_duty) && $stable(left_slow_ticks))
		else $error("result changed while stalled");

	// Only one half-bridge of a wheel is driven
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_fwd_duty == 7'd0 || left_rev_duty == 7'd0)
		&& (right_fwd_duty == 7'd0 || right_rev_duty == 7'd0))
		else $error("both channels of a wheel driven");

	// Duty never exceeds full scale
	a_duty_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_fwd_duty <= 7'd100 && left_rev_duty <= 7'd100
		&& right_fwd_duty <= 7'd100 && right_rev_duty <= 7'd100)
		else $error("duty above 100");

	// Slow counters saturate
	a_slow_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_slow_ticks <= 8'd200 && right_slow_ticks <= 8'd200)
		else $error("slow counter above saturation");

endmodule

bind dual_wheel_speed_regulator_top dwsr_checker u_dwsr_checker (.*);
`default_nettype wire

// ===== test/dual_wheel_speed_regulator_top_tb.sv =====
// Self-checking testbench for the dual wheel speed regulator: directed table plus random traffic.
`timescale 1ns / 100ps
module dual_wheel_speed_regulator_top_tb;
	import dwsr_pkg::*;

	// Codes the package leaves unnamed
	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam logic [1:0] DIR_UNUSED = 2'd3;

	localparam int unsigned CYCLE_LIMIT   = 100000;
	localparam int unsigned RANDOM_ITEMS  = 450;
	localparam int unsigned SAT_RUN_ITEMS = 215;
	localparam int unsigned PHASE_ITEMS   = 40;
	localparam int unsigned SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [6:0] lf;
		logic [6:0] lr;
		logic [6:0] rf;
		logic [6:0] rr;
		logic [7:0] ls;
		logic [7:0] rs;
	} drive_result_t;

	localparam drive_result_t NO_DRIVE = '0;

	// One directed request; cfg set means the settings are applied first
	typedef struct {
		bit            cfg;
		logic [6:0]    tl;
		logic [6:0]    tr;
		logic [1:0]    dl;
		logic [1:0]    dr;
		logic [1:0]    op;
		logic [7:0]    lc;
		logic [7:0]    rc;
		logic [7:0]    lp;
		logic [7:0]    rp;
		bit            typed;
		drive_result_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [6:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [1:0] operation;
	logic [7:0] left_count;
	logic [7:0] right_count;
	logic [7:0] left_preset;
	logic [7:0] right_preset;
	logic out_valid;
	logic out_ready;
	logic [6:0] left_fwd_duty;
	logic [6:0] left_rev_duty;
	logic [6:0] right_fwd_duty;
	logic [6:0] right_rev_duty;
	logic [7:0] left_slow_ticks;
	logic [7:0] right_slow_ticks;

	// Mirror of the block's settings and loop state
	logic [6:0] l_target, r_target;
	logic [1:0] l_dir, r_dir;
	logic [7:0] l_acc, r_acc;
	logic [7:0] l_slow, r_slow;

	drive_result_t expected_drive_q[$];
	plan_row_t directed_plan [20];

	int unsigned cycle_count;
	int unsigned mismatches;
	int unsigned burst_left;
	int unsigned sent_random;
	int stall_mode;
	bit quiet_sender;

	dual_wheel_speed_regulator_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.left_count(left_count),
		.right_count(right_count),
		.left_preset(left_preset),
		.right_preset(right_preset),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_fwd_duty(left_fwd_duty),
		.left_rev_duty(left_rev_duty),
		.right_fwd_duty(right_fwd_duty),
		.right_rev_duty(right_rev_duty),
		.left_slow_ticks(left_slow_ticks),
		.right_slow_ticks(right_slow_ticks)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Slow-tick counter: counts while well under target, clears otherwise
	function automatic logic [7:0] slow_step(logic [7:0] slow, logic [6:0] target,
			logic [7:0] count);
		int unsigned limit;
		limit = (int'(target) * 7) / 10;
		if (target > SLOW_MIN_TARGET && count < SLOW_MAX_COUNT && count < limit) begin
			return (slow >= SLOW_SAT) ? SLOW_SAT : slow + 8'd1;
		end
		return 8'd0;
	endfunction

	// Integral duty step with clamped count, clamped error and clamped sum
	function automatic logic [7:0] duty_step(logic [7:0] acc, logic [6:0] target,
			logic [7:0] count);
		int c;
		int err;
		int sum;
		if (target <= 7'd1) return 8'd0;
		c = (count > COUNT_CLAMP) ? int'(COUNT_CLAMP) : int'(count);
		err = int'(target) - c;
		if (err > ERR_LIMIT) err = ERR_LIMIT;
		if (err < -ERR_LIMIT) err = -ERR_LIMIT;
		sum = int'(acc) + err;
		if (sum < 0) sum = 0;
		else if (sum > DUTY_TOP) sum = DUTY_MAX;
		return sum[7:0];
	endfunction

	function automatic logic [6:0] route_duty(logic [1:0] dir, logic [7:0] duty,
			logic [1:0] channel);
		return (dir == channel) ? duty[6:0] : 7'd0;
	endfunction

	// Applies one accepted request to the mirror; returns 1 when a result follows
	function automatic bit predict_request(logic [1:0] op, logic [7:0] lc, logic [7:0] rc,
			logic [7:0] lp, logic [7:0] rp, output drive_result_t res);
		res = NO_DRIVE;
		case (op)
			OP_PRELOAD: begin
				l_acc = lp;
				r_acc = rp;
				return 1'b0;
			end
			OP_CLEAR: begin
				l_slow = 8'd0;
				r_slow = 8'd0;
				return 1'b0;
			end
			OP_TICK: begin
				l_slow = slow_step(l_slow, l_target, lc);
				r_slow = slow_step(r_slow, r_target, rc);
				l_acc = duty_step(l_acc, l_target, lc);
				r_acc = duty_step(r_acc, r_target, rc);
				res.lf = route_duty(l_dir, l_acc, DIR_FWD);
				res.lr = route_duty(l_dir, l_acc, DIR_REV);
				res.rf = route_duty(r_dir, r_acc, DIR_FWD);
				res.rr = route_duty(r_dir, r_acc, DIR_REV);
				res.ls = l_slow;
				res.rs = r_slow;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Lower valid and wait until every result is back and the pipe is quiet
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_drive_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [6:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_LEFT_TARGET: l_target = (data > TARGET_MAX) ? TARGET_MAX : data;
			REG_RIGHT_TARGET: r_target = (data > TARGET_MAX) ? TARGET_MAX : data;
			REG_LEFT_DIR: l_dir = data[1:0];
			default: r_dir = data[1:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Direction writes carry random upper bits, which the block must drop
	task automatic apply_settings(logic [6:0] tl, logic [6:0] tr, logic [1:0] dl,
			logic [1:0] dr);
		logic [4:0] junk_l;
		logic [4:0] junk_r;
		junk_l = 5'($urandom);
		junk_r = 5'($urandom);
		drain();
		write_reg(REG_LEFT_TARGET, tl);
		write_reg(REG_RIGHT_TARGET, tr);
		write_reg(REG_LEFT_DIR, {junk_l, dl});
		write_reg(REG_RIGHT_DIR, {junk_r, dr});
	endtask

	// Send one request in bursts with random gaps; predict on acceptance
	task automatic send_request(logic [1:0] op, logic [7:0] lc, logic [7:0] rc,
			logic [7:0] lp, logic [7:0] rp, bit typed, drive_result_t want);
		int unsigned gap;
		drive_result_t got;
		if (burst_left == 0) begin
			gap = quiet_sender ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 16);
			if (gap != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		left_count <= lc;
		right_count <= rc;
		left_preset <= lp;
		right_preset <= rp;
		do @(posedge clk); while (!in_ready);
		if (predict_request(op, lc, rc, lp, rp, got)) begin
			expected_drive_q.push_back(typed ? want : got);
		end
	endtask

	function automatic logic [6:0] pick_target();
		case ($urandom_range(0, 5))
			0: return 7'($urandom_range(0, 1));
			1: return 7'd2;
			2: return 7'($urandom_range(100, 127));
			3: return 7'($urandom_range(20, 22));
			default: return 7'($urandom_range(0, 127));
		endcase
	endfunction

	function automatic logic [7:0] pick_count(logic [6:0] target);
		int lo;
		int hi;
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 19));
			1: begin
				lo = (int'(target) > 12) ? int'(target) - 12 : 0;
				hi = int'(target) + 12;
				return 8'($urandom_range(lo, hi));
			end
			2: return 8'($urandom_range(60, 80));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_preset();
		if ($urandom_range(0, 3) == 0) return 8'($urandom_range(95, 104));
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly ticks, some preloads and clears, a few unused codes
	task automatic random_request();
		int unsigned pick;
		logic [1:0] op;
		pick = $urandom_range(0, 99);
		if (pick < 78) op = OP_TICK;
		else if (pick < 86) op = OP_PRELOAD;
		else if (pick < 93) op = OP_CLEAR;
		else op = OP_UNUSED;
		send_request(op, pick_count(l_target), pick_count(r_target), pick_preset(),
			pick_preset(), 1'b0, NO_DRIVE);
		if (op != OP_UNUSED) sent_random++;
	endtask

	// Receiver stall pattern, chosen at random from four modes
	always @(negedge clk) begin
		if (cycle_count % 48 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (cycle_count % 4 == 0);
			default: out_ready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	// Compare each delivered result with the oldest expectation
	always @(posedge clk) begin
		drive_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_drive_q.size() == 0) begin
				mismatches++;
				$display("%0t: drive result with nothing expected, expected none got %h",
					$time, {left_fwd_duty, left_rev_duty, right_fwd_duty, right_rev_duty,
					left_slow_ticks, right_slow_ticks});
			end else begin
				want = expected_drive_q.pop_front();
				check_field("left_fwd_duty", want.lf, left_fwd_duty);
				check_field("left_rev_duty", want.lr, left_rev_duty);
				check_field("right_fwd_duty", want.rf, right_fwd_duty);
				check_field("right_rev_duty", want.rr, right_rev_duty);
				check_field("left_slow_ticks", want.ls, left_slow_ticks);
				check_field("right_slow_ticks", want.rs, right_slow_ticks);
			end
		end
	end

	// Run watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("dual_wheel_speed_regulator_top_tb: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LEFT_TARGET;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = OP_TICK;
		left_count = '0;
		right_count = '0;
		left_preset = '0;
		right_preset = '0;
		out_ready = 1'b0;
		stall_mode = 0;
		cycle_count = 0;
		mismatches = 0;
		burst_left = 0;
		sent_random = 0;
		quiet_sender = 1'b0;
		l_target = '0;
		r_target = '0;
		l_dir = DIR_OFF;
		r_dir = DIR_OFF;
		l_acc = '0;
		r_acc = '0;
		l_slow = '0;
		r_slow = '0;

		// cfg tl tr dl dr | op lc rc lp rp | typed want
		directed_plan = '{
			// after reset everything is off
			'{0, 0, 0, DIR_OFF, DIR_OFF, OP_TICK, 255, 0, 0, 0, 1, NO_DRIVE},
			'{0, 0, 0, DIR_OFF, DIR_OFF, OP_UNUSED, 255, 255, 255, 255, 0, NO_DRIVE},
			// target write above range clamps to full; error clamps to +10
			'{1, 127, 1, DIR_FWD, DIR_REV, OP_TICK, 0, 0, 0, 0, 1,
				'{7'd10, 7'd0, 7'd0, 7'd0, 8'd1, 8'd0}},
			'{0, 0, 0, DIR_OFF, DIR_OFF, OP_PRELOAD, 0, 0, 255, 255, 0, NO_DRIVE},
			// oversized preload clamps to 100; target 1 forces duty to zero
			'{0, 0, 0, DIR_OFF, DIR_OFF, OP_TICK, 255, 255, 0, 0, 1,
				'{7'd100, 7'd0, 7'd0, 7'd0, 8'd0, 8'd0}},
			'{0, 0, 0, DIR_OFF, DIR_OFF, OP_TICK, 19, 0, 0, 0, 0, NO_DRIVE},
			'{0, 0, 0, DIR_OFF, DIR_OFF, OP_TICK, 19, 128, 0, 0, 0, NO_DRIVE},
			'{0, 0, 0, DIR_OFF, DIR_OFF, OP_CLEAR, 0, 0, 0, 0, 0, NO_DRIVE},
			'{0, 0, 0, DIR_OFF, DIR_OFF, OP_TICK, 0, 1, 0, 0, 0, NO_DRIVE},
			// unused direction drives nothing
			'{1, 2, 100, DIR_REV, DIR_UNUSED, OP_TICK, 70, 0, 0, 0, 0, NO_DRIVE},
			'{0, 0, 0, DIR_OFF, DIR_OFF, OP_PRELOAD, 0, 0, 0, 0, 0, NO_DRIVE},
			// negative error floors duty at zero
			'{0, 0, 0, DIR_OFF, DIR_OFF, OP_TICK, 255, 90, 0, 0, 1, NO_DRIVE},
			// slow threshold edges around target 21 and target 20
			'{1, 21, 20, DIR_FWD, DIR_FWD, OP_TICK, 13, 13, 0, 0, 0, NO_DRIVE},
			'{0, 0, 0, DIR_OFF, DIR_OFF, OP_TICK, 14, 19, 0, 0, 0, NO_DRIVE},
			'{0, 0, 0, DIR_OFF, DIR_OFF, OP_PRELOAD, 0, 0, 99, 100, 0, NO_DRIVE},
			'{0, 0, 0, DIR_OFF, DIR_OFF, OP_TICK, 21, 20, 0, 0, 0, NO_DRIVE},
			'{1, 0, 127, DIR_UNUSED, DIR_REV, OP_TICK, 0, 0, 0, 0, 0, NO_DRIVE},
			'{0, 0, 0, DIR_OFF, DIR_OFF, OP_PRELOAD, 0, 0, 128, 5, 0, NO_DRIVE},
			'{0, 0, 0, DIR_OFF, DIR_OFF, OP_TICK, 200, 255, 0, 0, 0, NO_DRIVE},
			'{0, 0, 0, DIR_OFF, DIR_OFF, OP_TICK, 100, 170, 0, 0, 0, NO_DRIVE}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table
		foreach (directed_plan[i]) begin
			if (directed_plan[i].cfg) begin
				apply_settings(directed_plan[i].tl, directed_plan[i].tr,
					directed_plan[i].dl, directed_plan[i].dr);
			end
			send_request(directed_plan[i].op, directed_plan[i].lc, directed_plan[i].rc,
				directed_plan[i].lp, directed_plan[i].rp, directed_plan[i].typed,
				directed_plan[i].want);
		end

		// Long slow-tick run so both slow counters reach saturation
		apply_settings(7'($urandom_range(100, 127)), 7'($urandom_range(30, 100)),
			2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
		repeat (SAT_RUN_ITEMS) begin
			if ($urandom_range(0, 19) == 0) begin
				send_request(OP_PRELOAD, 8'd0, 8'd0, pick_preset(), pick_preset(), 1'b0,
					NO_DRIVE);
			end else begin
				send_request(OP_TICK, 8'($urandom_range(0, 19)), 8'($urandom_range(0, 19)),
					8'($urandom), 8'($urandom), 1'b0, NO_DRIVE);
			end
			sent_random++;
		end

		// Random phases, each with fresh settings
		while (sent_random < RANDOM_ITEMS) begin
			apply_settings(pick_target(), pick_target(), 2'($urandom_range(0, 3)),
				2'($urandom_range(0, 3)));
			quiet_sender = ($urandom_range(0, 3) == 0);
			repeat (PHASE_ITEMS) random_request();
		end

		drain();
		repeat (6) @(posedge clk);
		if (mismatches == 0) begin
			$display("dual_wheel_speed_regulator_top_tb: clean");
		end else begin
			$display("dual_wheel_speed_regulator_top_tb: errors");
		end
		$finish;
	end

endmodule

// ===== dual_wheel_speed_regulator_top.f =====
hdl/dwsr_pkg.sv
hdl/dwsr_cfg.sv
hdl/dwsr_wheel.sv
hdl/dual_wheel_speed_regulator_top.sv
hdl/dwsr_checker.sv
test/dual_wheel_speed_regulator_top_tb.sv
